@@ design/nmea_sp_pkg.sv @@
// ============================================================================
// NMEA sentence parser package
// Shared types, codes and helper functions for the sentence parser core.
// ============================================================================
`default_nettype none

package nmea_sp_pkg;

   localparam int unsigned MAX_FIELD_INDEX_DEFAULT = 255;

   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   typedef enum logic [1:0] {
      PHASE_WAIT = 2'd0,
      PHASE_BODY = 2'd1,
      PHASE_TAIL = 2'd2,
      PHASE_BAD  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      KIND_IGNORED  = 3'd0,
      KIND_DATA     = 3'd1,
      KIND_SPACE    = 3'd2,
      KIND_SEP      = 3'd3,
      KIND_LINE_END = 3'd4,
      KIND_CHECKSUM = 3'd5
   } kind_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   byte_kind;
      logic [7:0] field_index;
      logic       sentence_end;
      logic       sentence_valid;
      logic [7:0] field_count;
      logic       checksum_checked;
   } result_type;

   // Space, tab, vertical tab, form feed and carriage return.
   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) ||
             (c == 8'h0D);
   endfunction

   // Upper-case hex character for one nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [3:0] masked;
      masked = n & NIBBLE_MASK;
      if (masked < 4'd10) begin
         return CHAR_ZERO + {4'd0, masked};
      end
      return CHAR_UPPER_A + {4'd0, masked} - 8'd10;
   endfunction

endpackage

`default_nettype wire

@@ design/nmea_sp_step.sv @@
// ============================================================================
// NMEA sentence parser line state
// Holds the per-line state and classifies one byte against it.
// ============================================================================
`default_nettype none

module nmea_sp_step #(
   parameter int unsigned MAX_FIELD_INDEX = nmea_sp_pkg::MAX_FIELD_INDEX_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [7:0]             rx_byte,
   output nmea_sp_pkg::result_type     result
);

   localparam logic [7:0] FieldLimit = MAX_FIELD_INDEX[7:0];

   nmea_sp_pkg::phase_type phase_ff, phase_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] field_ff, field_in;
   logic [1:0] tail_pos_ff, tail_pos_in;
   logic [1:0] solid_pos_ff, solid_pos_in;
   logic [7:0] tail_chars_ff [2];
   logic [7:0] tail_chars_in [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= nmea_sp_pkg::PHASE_WAIT;
         xor_ff           <= '0;
         field_ff         <= '0;
         tail_pos_ff      <= '0;
         solid_pos_ff     <= '0;
         tail_chars_ff[0] <= '0;
         tail_chars_ff[1] <= '0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         xor_ff           <= xor_in;
         field_ff         <= field_in;
         tail_pos_ff      <= tail_pos_in;
         solid_pos_ff     <= solid_pos_in;
         tail_chars_ff[0] <= tail_chars_in[0];
         tail_chars_ff[1] <= tail_chars_in[1];
      end
   end

   always_comb begin
      logic space;
      logic [1:0] pos_next;
      space            = nmea_sp_pkg::is_space(rx_byte);
      pos_next         = (tail_pos_ff < 2'd3) ? tail_pos_ff + 2'd1 : tail_pos_ff;
      phase_in         = phase_ff;
      xor_in           = xor_ff;
      field_in         = field_ff;
      tail_pos_in      = tail_pos_ff;
      solid_pos_in     = solid_pos_ff;
      tail_chars_in[0] = tail_chars_ff[0];
      tail_chars_in[1] = tail_chars_ff[1];

      result                  = '0;
      result.out_byte         = rx_byte;
      result.byte_kind        = nmea_sp_pkg::KIND_IGNORED;

      if (rx_byte == nmea_sp_pkg::CHAR_LF) begin
         result.byte_kind    = nmea_sp_pkg::KIND_LINE_END;
         result.sentence_end = 1'b1;
         if (phase_ff == nmea_sp_pkg::PHASE_BODY || phase_ff == nmea_sp_pkg::PHASE_TAIL) begin
            result.field_index    = field_ff;
            result.sentence_valid = 1'b1;
            if (phase_ff == nmea_sp_pkg::PHASE_TAIL && solid_pos_ff == 2'd2) begin
               result.checksum_checked = 1'b1;
               if (tail_chars_ff[0] != nmea_sp_pkg::hex_char(xor_ff[7:4]) ||
                   tail_chars_ff[1] != nmea_sp_pkg::hex_char(xor_ff[3:0])) begin
                  result.sentence_valid = 1'b0;
               end
            end
            if (result.sentence_valid) begin
               result.field_count = (field_ff == 8'hFF) ? 8'hFF : field_ff + 8'd1;
            end
         end
         // Every line end returns the line state to its reset values.
         phase_in         = nmea_sp_pkg::PHASE_WAIT;
         xor_in           = '0;
         field_in         = '0;
         tail_pos_in      = '0;
         solid_pos_in     = '0;
         tail_chars_in[0] = '0;
         tail_chars_in[1] = '0;
      end else begin
         unique case (phase_ff)
            nmea_sp_pkg::PHASE_WAIT: begin
               if (rx_byte == nmea_sp_pkg::CHAR_DOLLAR) begin
                  phase_in         = nmea_sp_pkg::PHASE_BODY;
                  result.byte_kind = nmea_sp_pkg::KIND_DATA;
               end else if (!space) begin
                  phase_in = nmea_sp_pkg::PHASE_BAD;
               end
            end
            nmea_sp_pkg::PHASE_BODY: begin
               result.field_index = field_ff;
               if (rx_byte == nmea_sp_pkg::CHAR_STAR) begin
                  result.byte_kind = nmea_sp_pkg::KIND_SEP;
                  phase_in         = nmea_sp_pkg::PHASE_TAIL;
               end else begin
                  xor_in = xor_ff ^ rx_byte;
                  if (rx_byte == nmea_sp_pkg::CHAR_COMMA) begin
                     result.byte_kind = nmea_sp_pkg::KIND_SEP;
                     if (field_ff < FieldLimit) begin
                        field_in = field_ff + 8'd1;
                     end
                  end else if (space) begin
                     result.byte_kind = nmea_sp_pkg::KIND_SPACE;
                  end else begin
                     result.byte_kind = nmea_sp_pkg::KIND_DATA;
                  end
               end
            end
            nmea_sp_pkg::PHASE_TAIL: begin
               result.field_index = field_ff;
               if (tail_pos_ff < 2'd2) begin
                  tail_chars_in[tail_pos_ff[0]] = rx_byte;
               end
               tail_pos_in = pos_next;
               if (space) begin
                  result.byte_kind = nmea_sp_pkg::KIND_SPACE;
               end else begin
                  result.byte_kind = nmea_sp_pkg::KIND_CHECKSUM;
                  solid_pos_in     = pos_next;
               end
            end
            nmea_sp_pkg::PHASE_BAD: begin
               phase_in = nmea_sp_pkg::PHASE_BAD;
            end
            default: begin
               phase_in = nmea_sp_pkg::PHASE_WAIT;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ design/nmea_sentence_parser_core.sv @@
// ============================================================================
// NMEA sentence parser core
// Byte-stream receiver that checks NMEA 0183 sentences and numbers fields.
// ============================================================================
// The core takes one received byte per word on the req channel and returns
// one tagged word per byte on the rsp channel, in order. It sustains one byte
// per clock cycle while the rsp channel does not stall. Each byte passes the
// input register and then the result register before it can be taken on the
// rsp side. Lines end with LF.
// Leading whitespace is skipped; the first solid byte must be '$', or the
// rest of the line is ignored and the line reports invalid. Bytes after '$'
// up to the first '*' are XORed and split on commas into numbered fields.
// After the '*', the first two bytes are compared, case sensitive, with the
// upper-case hex of the XOR, but only when the last solid byte after the '*'
// is the second byte after it; otherwise the check is left undone. At the LF
// word the core reports validity, the saturating field count and whether
// the checksum was compared. Trailing whitespace is tagged as whitespace
// rather than trimmed. The input side keeps taking bytes while a finished
// word waits on a stalled rsp channel, until both register stages are full.
// ============================================================================
`default_nettype none

module nmea_sentence_parser_core #(
   parameter int unsigned MAX_FIELD_INDEX = nmea_sp_pkg::MAX_FIELD_INDEX_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_rx_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_out_byte,
   output      logic [2:0] rsp_byte_kind,
   output      logic [7:0] rsp_field_index,
   output      logic       rsp_sentence_end,
   output      logic       rsp_sentence_valid,
   output      logic [7:0] rsp_field_count,
   output      logic       rsp_checksum_checked
);

   // Input register stage.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Result register stage.
   logic                    rsp_valid_ff, rsp_valid_in;
   nmea_sp_pkg::result_type rsp_data_ff;
   nmea_sp_pkg::result_type step_result;

   logic req_accept;
   logic out_free;
   logic move;

   // The result register can load whenever it is empty or being emptied.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign move       = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !out_free);
   assign rsp_valid_in = move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
      end
      if (move) begin
         rsp_data_ff <= step_result;
      end
   end

   // Line state only moves when the byte it classified is handed onward.
   nmea_sp_step #(
      .MAX_FIELD_INDEX(MAX_FIELD_INDEX)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (move),
      .rx_byte (in_byte_ff),
      .result  (step_result)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_byte         = rsp_data_ff.out_byte;
   assign rsp_byte_kind        = rsp_data_ff.byte_kind;
   assign rsp_field_index      = rsp_data_ff.field_index;
   assign rsp_sentence_end     = rsp_data_ff.sentence_end;
   assign rsp_sentence_valid   = rsp_data_ff.sentence_valid;
   assign rsp_field_count      = rsp_data_ff.field_count;
   assign rsp_checksum_checked = rsp_data_ff.checksum_checked;

   // The input side stalls only while its register holds a byte that cannot move.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("input stalled while a stage was free");

   // A line-end word always carries the line-end kind, and only it does.
   a_end_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sentence_end == (rsp_byte_kind == nmea_sp_pkg::KIND_LINE_END)))
      else $error("line end flag and byte kind disagree");

   // Line summary fields are zero on every word that is not a line end.
   a_summary_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_sentence_end) |->
         (!rsp_sentence_valid && !rsp_checksum_checked && rsp_field_count == 8'd0))
      else $error("summary fields set on a non-terminating byte");

   // A valid sentence always reports at least one field.
   a_valid_has_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sentence_valid) |-> (rsp_field_count != 8'd0))
      else $error("valid sentence with zero fields");

   // A byte moved into the result stage shows up on rsp in the next cycle.
   a_move_shows: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid)
      else $error("result word lost after moving out of the input stage");

endmodule

`default_nettype wire
